@@ hdl/adam_pkg.sv @@
`timescale 1ns / 1ps

package adam_pkg;

	// Decay rates and learning rates are Q0.24; the running decay powers are Q1.24.
	localparam int DECAY_BITS = 24;
	localparam logic [24:0] DECAY_ONE = 25'h100_0000;

	localparam logic [23:0] BETA1_RESET = 24'd15099494;
	localparam logic [23:0] BETA2_RESET = 24'd16760439;
	localparam logic [23:0] EPSILON_RESET = 24'd2;

	localparam logic MODE_BEGIN = 1'b0;
	localparam logic MODE_UPDATE = 1'b1;

	typedef enum logic [1:0] {
		CFG_BETA1   = 2'd0,
		CFG_BETA2   = 2'd1,
		CFG_EPSILON = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic               mode;
		logic [11:0]        index;
		logic signed [31:0] gradient;
		logic signed [31:0] current_weight;
		logic [23:0]        step_rate;
	} adam_cmd_t;

	typedef struct packed {
		logic [11:0]        result_index;
		logic signed [31:0] new_weight;
		logic               overflow;
	} adam_res_t;

endpackage

@@ hdl/adam_optimizer_update.sv @@
`timescale 1ns / 1ps

// Channel   Signals                                    Transfer
// item      start, busy, item                          start high while busy low
// result    result_valid, result                       one cycle strobe, no back-pressure
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  valid and ready both high
//
// A begin-step item passes through S_BEG_A, S_BEG_B and S_BEG_C. An update item at step zero answers on the next cycle.
// Any other update item passes through one index reduction state, one memory read,
// 9 multiplier states, 232 steps of the shared compare-subtract unit (56 + 56 + 88 divide,
// 32 root) and one finishing state.
// After reset the moment stores are cleared, one entry a cycle, until all ELEMENTS entries are zero.
// Busy stays high meanwhile. Results cannot be stalled; the next item may start
// while a result strobe is out.

module adam_optimizer_update #(
	parameter int ELEMENTS = 4096,
	parameter int FRACTION_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  adam_pkg::adam_cmd_t  item,
	output logic                 result_valid,
	output adam_pkg::adam_res_t  result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_data
);

	localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
	localparam int UP = (FRACTION_BITS > adam_pkg::DECAY_BITS) ?
		FRACTION_BITS - adam_pkg::DECAY_BITS : 0;
	localparam int DN = (adam_pkg::DECAY_BITS > FRACTION_BITS) ?
		adam_pkg::DECAY_BITS - FRACTION_BITS : 0;
	localparam int REM_W = 52;
	localparam int DV_W = 88;
	localparam int QUO_W = 57;
	localparam logic [31:0] ELEM_W = 32'(ELEMENTS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(ELEMENTS - 1);
	localparam logic [QUO_W-1:0] VCAP = QUO_W'((64'd1 << (64 - FRACTION_BITS)) - 64'd1);
	localparam logic [40:0] STEP_CAP = 41'h100_0000_0000;
	// Rounded-up reciprocal of ELEMENTS with 24 fraction bits.
	localparam logic [24:0] RED_RECIP =
		25'(((64'd1 << 24) + 64'(ELEMENTS) - 64'd1) / 64'(ELEMENTS));

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_BEG_A, S_BEG_B, S_BEG_C, S_RED, S_RD,
		S_MUL1, S_MUL2, S_MUL3, S_MUL4, S_MUL5, S_MUL6,
		S_DIVM, S_DIVV, S_SQRT, S_MUL7, S_MUL8, S_MUL9, S_DIVQ, S_FIN
	} state_t;

	state_t state_q;
	logic [AW-1:0] clr_q;
	logic [11:0] red_q;
	logic [11:0] idx_q;
	logic signed [31:0] g_q;
	logic signed [31:0] w_q;
	logic [23:0] rate_q;
	logic [23:0] b1_q;
	logic [23:0] b2_q;
	logic [23:0] eps_q;
	logic [24:0] bp1_q;
	logic [24:0] bp2_q;
	logic [31:0] step_q;
	logic signed [31:0] m_q;
	logic [31:0] sq_q;
	logic [31:0] v_q;
	logic [55:0] mhat_q;
	logic [REM_W-1:0] den_q;
	logic [REM_W-1:0] rem_q;
	logic [DV_W-1:0] dvd_q;
	logic [QUO_W-1:0] quo_q;
	logic [6:0] cnt_q;
	logic big_q;
	logic ovf_q;
	logic signed [65:0] acc_q;
	logic signed [65:0] prod_q;
	logic res_valid_q;
	adam_pkg::adam_res_t res_q;

	logic [31:0] mem_m [ELEMENTS];
	logic [31:0] mem_v [ELEMENTS];
	logic [31:0] rd_m_q;
	logic [31:0] rd_v_q;
	logic mem_we;
	logic [AW-1:0] mem_wa;
	logic [AW-1:0] slot;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] acc_sum;
	logic [63:0] sqfull;
	logic [31:0] magg;
	logic [31:0] magm;
	logic [24:0] om1;
	logic [24:0] om2;
	logic [24:0] c1;
	logic [24:0] c2;
	logic [36:0] red_prod;
	logic [11:0] red_quo;
	logic [31:0] red_back;
	logic is_sqrt;
	logic [REM_W-1:0] cs_in;
	logic [REM_W-1:0] cs_d;
	logic cs_ge;
	logic [REM_W-1:0] cs_rem;
	logic [QUO_W-1:0] quo_nxt;
	logic [DV_W-1:0] dvd_nxt;
	logic vcap_hit;
	logic [QUO_W-1:0] vhat_c;
	logic [33:0] root_sum;
	logic [33:0] den_sum;
	logic [DV_W-1:0] step_prod;
	logic [40:0] q41;
	logic signed [42:0] nw;
	logic nw_hi;
	logic nw_lo;

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign result_valid = res_valid_q;
	assign result = res_q;

	assign slot = AW'(red_q);
	assign mem_we = (state_q == S_CLEAR) || (state_q == S_MUL6);
	assign mem_wa = (state_q == S_CLEAR) ? clr_q : slot;

	assign om1 = adam_pkg::DECAY_ONE - {1'b0, b1_q};
	assign om2 = adam_pkg::DECAY_ONE - {1'b0, b2_q};
	// A decay power of one would leave nothing to correct by; one LSB stands in.
	assign c1 = (bp1_q >= adam_pkg::DECAY_ONE) ? 25'd1 : adam_pkg::DECAY_ONE - bp1_q;
	assign c2 = (bp2_q >= adam_pkg::DECAY_ONE) ? 25'd1 : adam_pkg::DECAY_ONE - bp2_q;
	assign magg = g_q[31] ? (~g_q + 32'd1) : g_q;
	assign magm = m_q[31] ? (~m_q + 32'd1) : m_q;
	assign acc_sum = acc_q + prod_q;
	assign sqfull = prod_q[63:0] >> FRACTION_BITS;
	// The quotient is exact for every 12-bit index with 24 reciprocal fraction bits.
	assign red_prod = 37'(red_q) * 37'(RED_RECIP);
	assign red_quo = red_prod[35:24];
	assign red_back = 32'(red_quo) * ELEM_W;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_BEG_A: begin
				mul_a = $signed({8'd0, bp1_q});
				mul_b = $signed({9'd0, b1_q});
			end
			S_BEG_B: begin
				mul_a = $signed({8'd0, bp2_q});
				mul_b = $signed({9'd0, b2_q});
			end
			S_MUL1: begin
				mul_a = $signed({9'd0, b1_q});
				mul_b = $signed({rd_m_q[31], rd_m_q});
			end
			S_MUL2: begin
				mul_a = $signed({8'd0, om1});
				mul_b = $signed({g_q[31], g_q});
			end
			S_MUL3: begin
				mul_a = $signed({1'b0, magg});
				mul_b = $signed({1'b0, magg});
			end
			S_MUL4: begin
				mul_a = $signed({9'd0, b2_q});
				mul_b = $signed({1'b0, rd_v_q});
			end
			S_MUL5: begin
				mul_a = $signed({8'd0, om2});
				mul_b = $signed({1'b0, sq_q});
			end
			S_MUL7: begin
				mul_a = $signed({1'b0, mhat_q[31:0]});
				mul_b = $signed({9'd0, rate_q});
			end
			S_MUL8: begin
				mul_a = $signed({9'd0, mhat_q[55:32]});
				mul_b = $signed({9'd0, rate_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Shared compare-subtract unit: one restoring divide bit, or one root digit.
	always_comb begin
		is_sqrt = (state_q == S_SQRT);
		if (is_sqrt) begin
			cs_in = {rem_q[REM_W-3:0], dvd_q[DV_W-1 -: 2]};
			cs_d = {quo_q[REM_W-3:0], 2'b01};
			dvd_nxt = dvd_q << 2;
		end else begin
			cs_in = {rem_q[REM_W-2:0], dvd_q[DV_W-1]};
			cs_d = den_q;
			dvd_nxt = dvd_q << 1;
		end
		cs_ge = (cs_in >= cs_d);
		cs_rem = cs_ge ? (cs_in - cs_d) : cs_in;
		quo_nxt = {quo_q[QUO_W-2:0], cs_ge};
	end

	always_comb begin
		vcap_hit = (quo_nxt > VCAP);
		vhat_c = vcap_hit ? VCAP : quo_nxt;
		root_sum = 34'(quo_nxt[32:0]) + 34'(eps_q);
		den_sum = (root_sum == 34'd0) ? 34'd1 : root_sum;
		step_prod = DV_W'(acc_q[55:0]) + (DV_W'(prod_q[47:0]) << 32);
		q41 = big_q ? STEP_CAP : quo_q[40:0];
		nw = m_q[31] ? (43'(w_q) + $signed({2'b00, q41}))
			: (43'(w_q) - $signed({2'b00, q41}));
		nw_hi = (nw > 43'sd2147483647);
		nw_lo = (nw < -43'sd2147483648);
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		rd_m_q <= mem_m[slot];
		rd_v_q <= mem_v[slot];
		if (mem_we) begin
			mem_m[mem_wa] <= (state_q == S_CLEAR) ? 32'd0 : m_q;
			mem_v[mem_wa] <= (state_q == S_CLEAR) ? 32'd0 : acc_sum[adam_pkg::DECAY_BITS +: 32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			red_q <= '0;
			idx_q <= '0;
			g_q <= '0;
			w_q <= '0;
			rate_q <= '0;
			b1_q <= adam_pkg::BETA1_RESET;
			b2_q <= adam_pkg::BETA2_RESET;
			eps_q <= adam_pkg::EPSILON_RESET;
			bp1_q <= adam_pkg::DECAY_ONE;
			bp2_q <= adam_pkg::DECAY_ONE;
			step_q <= '0;
			m_q <= '0;
			sq_q <= '0;
			v_q <= '0;
			mhat_q <= '0;
			den_q <= '0;
			rem_q <= '0;
			dvd_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
			big_q <= 1'b0;
			ovf_q <= 1'b0;
			acc_q <= '0;
			res_valid_q <= 1'b0;
			res_q <= '0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					adam_pkg::CFG_BETA1: b1_q <= cfg_data;
					adam_pkg::CFG_BETA2: b2_q <= cfg_data;
					adam_pkg::CFG_EPSILON: eps_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						idx_q <= item.index;
						g_q <= item.gradient;
						w_q <= item.current_weight;
						red_q <= item.index;
						ovf_q <= 1'b0;
						if (item.mode == adam_pkg::MODE_BEGIN) begin
							if (step_q != 32'hFFFF_FFFF) begin
								step_q <= step_q + 32'd1;
							end
							rate_q <= item.step_rate;
							state_q <= S_BEG_A;
						end else if (step_q == 32'd0) begin
							res_valid_q <= 1'b1;
							res_q <= '{result_index: item.index,
								new_weight: item.current_weight, overflow: 1'b1};
						end else begin
							state_q <= S_RED;
						end
					end
				end
				S_BEG_A: state_q <= S_BEG_B;
				S_BEG_B: begin
					bp1_q <= prod_q[48:24];
					state_q <= S_BEG_C;
				end
				S_BEG_C: begin
					bp2_q <= prod_q[48:24];
					state_q <= S_IDLE;
				end
				S_RED: begin
					// Index modulo ELEMENTS by reciprocal multiplication.
					red_q <= red_q - red_back[11:0];
					state_q <= S_RD;
				end
				S_RD: state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: begin
					acc_q <= prod_q;
					state_q <= S_MUL3;
				end
				S_MUL3: begin
					m_q <= acc_sum[adam_pkg::DECAY_BITS +: 32];
					state_q <= S_MUL4;
				end
				S_MUL4: begin
					if (|sqfull[63:32]) begin
						sq_q <= 32'hFFFF_FFFF;
						ovf_q <= 1'b1;
					end else begin
						sq_q <= sqfull[31:0];
					end
					state_q <= S_MUL5;
				end
				S_MUL5: begin
					acc_q <= prod_q;
					state_q <= S_MUL6;
				end
				S_MUL6: begin
					v_q <= acc_sum[adam_pkg::DECAY_BITS +: 32];
					dvd_q <= {magm, 56'd0};
					den_q <= REM_W'(c1);
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= 7'd56;
					state_q <= S_DIVM;
				end
				S_DIVM: begin
					rem_q <= cs_rem;
					dvd_q <= dvd_nxt;
					quo_q <= quo_nxt;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						mhat_q <= quo_nxt[55:0];
						dvd_q <= {v_q, 56'd0};
						den_q <= REM_W'(c2);
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= 7'd56;
						state_q <= S_DIVV;
					end
				end
				S_DIVV: begin
					rem_q <= cs_rem;
					dvd_q <= dvd_nxt;
					quo_q <= quo_nxt;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						if (vcap_hit) begin
							ovf_q <= 1'b1;
						end
						dvd_q <= {64'(vhat_c) << FRACTION_BITS, 24'd0};
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= 7'd32;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					rem_q <= cs_rem;
					dvd_q <= dvd_nxt;
					quo_q <= quo_nxt;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						den_q <= REM_W'(den_sum) << DN;
						state_q <= S_MUL7;
					end
				end
				S_MUL7: state_q <= S_MUL8;
				S_MUL8: begin
					acc_q <= prod_q;
					state_q <= S_MUL9;
				end
				S_MUL9: begin
					dvd_q <= step_prod << UP;
					rem_q <= '0;
					quo_q <= '0;
					big_q <= 1'b0;
					cnt_q <= 7'd88;
					state_q <= S_DIVQ;
				end
				S_DIVQ: begin
					// Quotient bits past the cap are lost; the sticky flag keeps the answer.
					rem_q <= cs_rem;
					dvd_q <= dvd_nxt;
					quo_q <= quo_nxt;
					big_q <= big_q | (|quo_nxt[QUO_W-1:40]);
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					res_valid_q <= 1'b1;
					res_q.result_index <= idx_q;
					if (nw_hi) begin
						res_q.new_weight <= 32'sh7FFF_FFFF;
					end else if (nw_lo) begin
						res_q.new_weight <= 32'sh8000_0000;
					end else begin
						res_q.new_weight <= nw[31:0];
					end
					res_q.overflow <= ovf_q | big_q | nw_hi | nw_lo;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($past(state_q) == S_FIN || $past(state_q) == S_IDLE))
		else $error("result strobe without a finishing state");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVQ || state_q == S_DIVM || state_q == S_DIVV) |-> (den_q != '0))
		else $error("division by zero in shared unit");

	a_begin_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.mode == adam_pkg::MODE_BEGIN) |=> !result_valid)
		else $error("begin-step item produced a result");

	a_busy_release: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> ($past(state_q) == S_FIN || $past(state_q) == S_BEG_C
			|| $past(state_q) == S_CLEAR))
		else $error("busy dropped in the middle of an item");

endmodule

@@ bench/adam_optimizer_update_tb.sv @@
`timescale 1ns / 1ps

module adam_optimizer_update_tb;

	localparam int NUM_ELEMENTS = 4096;
	localparam int FRAC = 24;
	localparam longint CYCLE_LIMIT = 3_000_000;
	localparam int RANDOM_PER_PHASE = 225;

	typedef struct {
		adam_pkg::adam_cmd_t cmd;
		bit                  literal;
		adam_pkg::adam_res_t lit_res;
	} stim_row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	adam_pkg::adam_cmd_t item;
	logic      result_valid;
	adam_pkg::adam_res_t result;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	// Predictor state.
	logic signed [31:0] m_store [NUM_ELEMENTS];
	logic [31:0]        v_store [NUM_ELEMENTS];
	logic [31:0]        step_cnt;
	logic [31:0]        b1_pow;
	logic [31:0]        b2_pow;
	logic [23:0]        rate_held;
	logic [23:0]        b1_reg;
	logic [23:0]        b2_reg;
	logic [23:0]        eps_reg;

	adam_pkg::adam_res_t weight_queue [$];
	int        mismatches;
	int        updates_seen;
	int        overflows_seen;
	int        begins_sent;
	longint    cycles;

	adam_optimizer_update i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				weight_queue.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic [31:0] int_sqrt(logic [63:0] x);
		logic [31:0] r;
		logic [31:0] trial;
		r = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = r | (32'd1 << b);
			if (64'(trial) * 64'(trial) <= x)
				r = trial;
		end
		return r;
	endfunction

	// Advances the predictor by one item. Returns 1 when the item produces a weight.
	function automatic bit predict_weight(adam_pkg::adam_cmd_t c,
			output adam_pkg::adam_res_t res);
		longint signed g, w, acc, m, nw;
		logic [63:0] mag, sq, v, c1, c2, mhat, vhat, root, den, q;
		logic [127:0] prod, quot;
		bit ovf;
		int slot;
		ovf = 1'b0;
		res = '0;
		slot = c.index % NUM_ELEMENTS;
		if (c.mode == adam_pkg::MODE_BEGIN) begin
			if (step_cnt != 32'hFFFF_FFFF)
				step_cnt = step_cnt + 1;
			b1_pow = 32'((64'(b1_pow) * 64'(b1_reg)) >> adam_pkg::DECAY_BITS);
			b2_pow = 32'((64'(b2_pow) * 64'(b2_reg)) >> adam_pkg::DECAY_BITS);
			rate_held = c.step_rate;
			return 1'b0;
		end
		g = c.gradient;
		w = c.current_weight;
		res.result_index = c.index;
		if (step_cnt == 0) begin
			res.new_weight = c.current_weight;
			res.overflow = 1'b1;
			return 1'b1;
		end
		acc = longint'(b1_reg) * longint'(m_store[slot])
			+ (longint'(adam_pkg::DECAY_ONE) - longint'(b1_reg)) * g;
		m = acc >>> adam_pkg::DECAY_BITS;
		m_store[slot] = m[31:0];

		mag = (g < 0) ? -g : g;
		sq = (mag * mag) >> FRAC;
		if (sq > 64'hFFFF_FFFF) begin
			sq = 64'hFFFF_FFFF;
			ovf = 1'b1;
		end
		v = (64'(b2_reg) * 64'(v_store[slot])
			+ (64'(adam_pkg::DECAY_ONE) - 64'(b2_reg)) * sq) >> adam_pkg::DECAY_BITS;
		v_store[slot] = v[31:0];

		c1 = 64'(adam_pkg::DECAY_ONE) - 64'(b1_pow[24:0]);
		c2 = 64'(adam_pkg::DECAY_ONE) - 64'(b2_pow[24:0]);
		if (c1 == 0 || c1 > 64'(adam_pkg::DECAY_ONE))
			c1 = 1;
		if (c2 == 0 || c2 > 64'(adam_pkg::DECAY_ONE))
			c2 = 1;
		mag = (m < 0) ? -m : m;
		mhat = (mag << adam_pkg::DECAY_BITS) / c1;
		vhat = (v << adam_pkg::DECAY_BITS) / c2;
		if (vhat > (64'd1 << (64 - FRAC)) - 1) begin
			vhat = (64'd1 << (64 - FRAC)) - 1;
			ovf = 1'b1;
		end
		root = 64'(int_sqrt(vhat << FRAC));
		den = root + 64'(eps_reg);
		if (den == 0)
			den = 1;

		// The step is capped at 2^40 once the full quotient reaches it.
		prod = 128'(mhat) * 128'(rate_held);
		quot = prod / 128'(den);
		if (quot >= (128'd1 << 40)) begin
			q = 64'd1 << 40;
			ovf = 1'b1;
		end else begin
			q = quot[63:0];
		end

		nw = (m < 0) ? w + longint'(q) : w - longint'(q);
		if (nw > 64'sd2147483647) begin
			nw = 64'sd2147483647;
			ovf = 1'b1;
		end else if (nw < -64'sd2147483648) begin
			nw = -64'sd2147483648;
			ovf = 1'b1;
		end
		res.new_weight = nw[31:0];
		res.overflow = ovf;
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		adam_pkg::adam_res_t exp_res;
		if (result_valid) begin
			updates_seen <= updates_seen + 1;
			if (result.overflow)
				overflows_seen <= overflows_seen + 1;
			if (weight_queue.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("unexpected result: index %0d weight %0d overflow %0b",
						result.result_index, result.new_weight, result.overflow);
			end else begin
				exp_res = weight_queue.pop_front();
				if (result.result_index !== exp_res.result_index
						|| result.new_weight !== exp_res.new_weight
						|| result.overflow !== exp_res.overflow) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("mismatch: expected index %0d weight %0d overflow %0b, got index %0d weight %0d overflow %0b",
							exp_res.result_index, exp_res.new_weight,
							exp_res.overflow, result.result_index,
							result.new_weight, result.overflow);
				end
			end
		end
	end

	function automatic int gap_cycles();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 0;
		if (sel < 93)
			return $urandom_range(1, 4);
		return $urandom_range(15, 60);
	endfunction

	task automatic idle_gap();
		int n;
		n = gap_cycles();
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Presents one item and holds it until the block takes it.
	task automatic send_item(adam_pkg::adam_cmd_t c, bit literal,
			adam_pkg::adam_res_t lit_res);
		adam_pkg::adam_res_t pred;
		@(negedge clk);
		start <= 1'b1;
		item <= c;
		do @(posedge clk); while (busy);
		if (c.mode == adam_pkg::MODE_BEGIN)
			begins_sent++;
		if (predict_weight(c, pred))
			weight_queue.push_back(literal ? lit_res : pred);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (weight_queue.size() != 0) @(posedge clk);
		// A begin-step transfer leaves no result, so give it time to finish.
		repeat (6) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(adam_pkg::cfg_reg_t idx, logic [23:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			adam_pkg::CFG_BETA1: begin
				b1_reg = value;
			end
			adam_pkg::CFG_BETA2: begin
				b2_reg = value;
			end
			default: begin
				eps_reg = value;
			end
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic adam_pkg::adam_cmd_t random_item();
		adam_pkg::adam_cmd_t c;
		int sel;
		c.mode = ($urandom_range(0, 99) < 10) ? adam_pkg::MODE_BEGIN : adam_pkg::MODE_UPDATE;
		c.index = ($urandom_range(0, 1) == 0) ? 12'($urandom_range(0, 15)) : 12'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 5)
			c.gradient = '0;
		else if (sel < 50)
			c.gradient = 32'(int'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000);
		else
			c.gradient = $urandom;
		c.current_weight = ($urandom_range(0, 1) == 0) ? $urandom
			: 32'(int'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000);
		c.step_rate = 24'($urandom);
		return c;
	endfunction

	function automatic adam_pkg::adam_cmd_t make_cmd(logic mode, logic [11:0] idx,
			logic [31:0] g, logic [31:0] w, logic [23:0] rate);
		adam_pkg::adam_cmd_t c;
		c.mode = mode;
		c.index = idx;
		c.gradient = g;
		c.current_weight = w;
		c.step_rate = rate;
		return c;
	endfunction

	initial begin
		stim_row_t rows [$];
		stim_row_t row;
		adam_pkg::adam_res_t none;
		logic [23:0] cfg_set [4][3];
		none = '0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = adam_pkg::CFG_BETA1;
		cfg_data = '0;
		arst_n = 1'b0;
		cycles = 0;
		mismatches = 0;
		updates_seen = 0;
		overflows_seen = 0;
		begins_sent = 0;
		for (int i = 0; i < NUM_ELEMENTS; i++) begin
			m_store[i] = '0;
			v_store[i] = '0;
		end
		step_cnt = '0;
		b1_pow = 32'(adam_pkg::DECAY_ONE);
		b2_pow = 32'(adam_pkg::DECAY_ONE);
		rate_held = '0;
		b1_reg = adam_pkg::BETA1_RESET;
		b2_reg = adam_pkg::BETA2_RESET;
		eps_reg = adam_pkg::EPSILON_RESET;

		// Updates before the first step echo the weight and raise the flag.
		row.cmd = make_cmd(adam_pkg::MODE_UPDATE, 12'd0, 32'h7FFF_FFFF, 32'h8000_0000,
			24'hFFFFFF);
		row.literal = 1'b1;
		row.lit_res = '{result_index: 12'd0, new_weight: 32'h8000_0000, overflow: 1'b1};
		rows.push_back(row);
		row.cmd = make_cmd(adam_pkg::MODE_UPDATE, 12'd4095, 32'h8000_0000, 32'h7FFF_FFFF,
			24'd0);
		row.lit_res = '{result_index: 12'd4095, new_weight: 32'h7FFF_FFFF, overflow: 1'b1};
		rows.push_back(row);
		row.literal = 1'b0;
		row.lit_res = none;
		row.cmd = make_cmd(adam_pkg::MODE_BEGIN, 12'd0, 32'd0, 32'd0, 24'hFFFFFF);
		rows.push_back(row);
		row.cmd = make_cmd(adam_pkg::MODE_UPDATE, 12'd1, 32'd0, 32'd0, 24'd0);
		rows.push_back(row);
		row.cmd = make_cmd(adam_pkg::MODE_UPDATE, 12'd2, 32'h8000_0000, 32'h7FFF_FFFF,
			24'd0);
		rows.push_back(row);
		row.cmd = make_cmd(adam_pkg::MODE_UPDATE, 12'd3, 32'h7FFF_FFFF, 32'h8000_0000,
			24'd0);
		rows.push_back(row);
		row.cmd = make_cmd(adam_pkg::MODE_UPDATE, 12'd3, 32'h0100_0000, 32'd0, 24'd0);
		rows.push_back(row);
		row.cmd = make_cmd(adam_pkg::MODE_UPDATE, 12'd4095, 32'hFF00_0000, 32'd12345, 24'd0);
		rows.push_back(row);
		row.cmd = make_cmd(adam_pkg::MODE_BEGIN, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			24'd0);
		rows.push_back(row);
		row.cmd = make_cmd(adam_pkg::MODE_UPDATE, 12'd5, 32'h0010_0000, 32'hFFFF_FFFF, 24'd0);
		rows.push_back(row);
		row.cmd = make_cmd(adam_pkg::MODE_BEGIN, 12'd0, 32'd0, 32'd0, 24'h800000);
		rows.push_back(row);
		row.cmd = make_cmd(adam_pkg::MODE_UPDATE, 12'd6, 32'hFFFF_FC00, 32'd0, 24'd0);
		rows.push_back(row);
		row.cmd = make_cmd(adam_pkg::MODE_UPDATE, 12'd2048, 32'h0000_0001, 32'h7FFF_FF00,
			24'd0);
		rows.push_back(row);

		cfg_set[0] = '{24'd0, 24'd0, 24'd0};
		cfg_set[1] = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
		cfg_set[2] = '{24'($urandom), 24'($urandom), 24'($urandom_range(0, 1000))};
		cfg_set[3] = '{adam_pkg::BETA1_RESET, adam_pkg::BETA2_RESET,
			adam_pkg::EPSILON_RESET};

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			send_item(rows[i].cmd, rows[i].literal, rows[i].lit_res);
			idle_gap();
		end

		for (int p = 0; p < 4; p++) begin
			wait_idle();
			write_reg(adam_pkg::CFG_BETA1, cfg_set[p][0]);
			write_reg(adam_pkg::CFG_BETA2, cfg_set[p][1]);
			write_reg(adam_pkg::CFG_EPSILON, cfg_set[p][2]);
			// A fresh element with a zero gradient drives the divisor toward zero.
			send_item(make_cmd(adam_pkg::MODE_UPDATE, 12'd100 + 12'(p), 32'd0, 32'd77,
				24'd0), 1'b0, none);
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				send_item(random_item(), 1'b0, none);
				idle_gap();
			end
		end

		wait_idle();
		repeat (300) @(posedge clk);
		$display("Sent %0d begin-step transfers and checked %0d weights (%0d flagged),",
			begins_sent, updates_seen, overflows_seen);
		$display("over four decay and epsilon settings including both extremes.");
		if (mismatches == 0 && weight_queue.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, weight_queue.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
